// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL; they expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define AST_SAME(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle check failed");
// next-cycle implication
`define AST_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle check failed");
`else
`define AST_SAME(lbl, pre, post)
`define AST_NEXT(lbl, pre, post)
`endif
`endif

// ===== rtl/tpma_pkg.sv =====
// ----------------------------------------------------------------------------
// tpma_pkg
// Types, constants and micro-op program of the triangle point mapper.
// ----------------------------------------------------------------------------
`default_nettype none
package tpma_pkg;

  localparam int CW   = 32;   // coordinate width
  localparam int WIDE = 176;  // datapath width, holds every exact intermediate

  localparam logic [1:0] CMD_SRC = 2'd0;
  localparam logic [1:0] CMD_TGT = 2'd1;
  localparam logic [1:0] CMD_MAP = 2'd2;
  localparam logic [1:0] SLOT_NONE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE, ST_FETCH_A, ST_FETCH_B, ST_EXEC, ST_ROUND, ST_EMIT
  } state_t;

  typedef enum logic [2:0] {
    OP_SUB, OP_MUL, OP_MLA, OP_MLS, OP_CHK, OP_DIV, OP_END
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [4:0] dst;
    logic [5:0] sa;
    logic [5:0] sb;
  } uop_t;

  // operand codes: vertex store and point (bit 5 clear)
  localparam logic [5:0] V_A  = 6'd0;
  localparam logic [5:0] V_B  = 6'd3;
  localparam logic [5:0] V_C  = 6'd6;
  localparam logic [5:0] V_TA = 6'd9;
  localparam logic [5:0] V_TB = 6'd12;
  localparam logic [5:0] V_TC = 6'd15;
  localparam logic [5:0] V_P  = 6'd18;
  localparam logic [5:0] NUM_VERT = 6'd18;

  // scratch register indexes
  localparam logic [4:0] R_AB  = 5'd0;
  localparam logic [4:0] R_AC  = 5'd3;
  localparam logic [4:0] R_AP  = 5'd6;
  localparam logic [4:0] R_TAB = 5'd9;
  localparam logic [4:0] R_TAC = 5'd12;
  localparam logic [4:0] R_S   = 5'd15;
  localparam logic [4:0] R_Q   = 5'd16;
  localparam logic [4:0] R_L   = 5'd17;
  localparam logic [4:0] R_U   = 5'd18;
  localparam logic [4:0] R_W   = 5'd19;
  localparam logic [4:0] R_TS  = 5'd20;
  localparam logic [4:0] R_TQ  = 5'd21;
  localparam logic [4:0] R_TL  = 5'd22;
  localparam logic [4:0] R_D   = 5'd23;
  localparam logic [4:0] R_DT  = 5'd24;
  localparam logic [4:0] R_N1  = 5'd25;
  localparam logic [4:0] R_N2  = 5'd26;
  localparam logic [4:0] R_X   = 5'd27;

  function automatic logic [5:0] rc(input logic [4:0] i);
    return {1'b1, i};
  endfunction

  function automatic uop_t mk(input op_t o, input logic [4:0] d,
                              input logic [5:0] a, input logic [5:0] b);
    uop_t u;
    u.op = o; u.dst = d; u.sa = a; u.sb = b;
    return u;
  endfunction

  // Micro-op program: P' = TA + (N1*TAC + N2*TAB) / D, evaluated exactly
  function automatic uop_t prog(input logic [5:0] pc);
    case (pc)
      6'd0:  return mk(OP_SUB, R_AB,      V_B,       V_A);
      6'd1:  return mk(OP_SUB, R_AB+5'd1, V_B+6'd1,  V_A+6'd1);
      6'd2:  return mk(OP_SUB, R_AB+5'd2, V_B+6'd2,  V_A+6'd2);
      6'd3:  return mk(OP_SUB, R_AC,      V_C,       V_A);
      6'd4:  return mk(OP_SUB, R_AC+5'd1, V_C+6'd1,  V_A+6'd1);
      6'd5:  return mk(OP_SUB, R_AC+5'd2, V_C+6'd2,  V_A+6'd2);
      6'd6:  return mk(OP_SUB, R_AP,      V_P,       V_A);
      6'd7:  return mk(OP_SUB, R_AP+5'd1, V_P+6'd1,  V_A+6'd1);
      6'd8:  return mk(OP_SUB, R_AP+5'd2, V_P+6'd2,  V_A+6'd2);
      6'd9:  return mk(OP_SUB, R_TAB,      V_TB,      V_TA);
      6'd10: return mk(OP_SUB, R_TAB+5'd1, V_TB+6'd1, V_TA+6'd1);
      6'd11: return mk(OP_SUB, R_TAB+5'd2, V_TB+6'd2, V_TA+6'd2);
      6'd12: return mk(OP_SUB, R_TAC,      V_TC,      V_TA);
      6'd13: return mk(OP_SUB, R_TAC+5'd1, V_TC+6'd1, V_TA+6'd1);
      6'd14: return mk(OP_SUB, R_TAC+5'd2, V_TC+6'd2, V_TA+6'd2);
      // s = ab.ac
      6'd15: return mk(OP_MUL, R_S, rc(R_AB),      rc(R_AC));
      6'd16: return mk(OP_MLA, R_S, rc(R_AB+5'd1), rc(R_AC+5'd1));
      6'd17: return mk(OP_MLA, R_S, rc(R_AB+5'd2), rc(R_AC+5'd2));
      // q = ac.ac
      6'd18: return mk(OP_MUL, R_Q, rc(R_AC),      rc(R_AC));
      6'd19: return mk(OP_MLA, R_Q, rc(R_AC+5'd1), rc(R_AC+5'd1));
      6'd20: return mk(OP_MLA, R_Q, rc(R_AC+5'd2), rc(R_AC+5'd2));
      // L = ab.ab
      6'd21: return mk(OP_MUL, R_L, rc(R_AB),      rc(R_AB));
      6'd22: return mk(OP_MLA, R_L, rc(R_AB+5'd1), rc(R_AB+5'd1));
      6'd23: return mk(OP_MLA, R_L, rc(R_AB+5'd2), rc(R_AB+5'd2));
      // u = ap.ac
      6'd24: return mk(OP_MUL, R_U, rc(R_AP),      rc(R_AC));
      6'd25: return mk(OP_MLA, R_U, rc(R_AP+5'd1), rc(R_AC+5'd1));
      6'd26: return mk(OP_MLA, R_U, rc(R_AP+5'd2), rc(R_AC+5'd2));
      // w = ap.ab
      6'd27: return mk(OP_MUL, R_W, rc(R_AP),      rc(R_AB));
      6'd28: return mk(OP_MLA, R_W, rc(R_AP+5'd1), rc(R_AB+5'd1));
      6'd29: return mk(OP_MLA, R_W, rc(R_AP+5'd2), rc(R_AB+5'd2));
      // target S, Q, L
      6'd30: return mk(OP_MUL, R_TS, rc(R_TAB),      rc(R_TAC));
      6'd31: return mk(OP_MLA, R_TS, rc(R_TAB+5'd1), rc(R_TAC+5'd1));
      6'd32: return mk(OP_MLA, R_TS, rc(R_TAB+5'd2), rc(R_TAC+5'd2));
      6'd33: return mk(OP_MUL, R_TQ, rc(R_TAC),      rc(R_TAC));
      6'd34: return mk(OP_MLA, R_TQ, rc(R_TAC+5'd1), rc(R_TAC+5'd1));
      6'd35: return mk(OP_MLA, R_TQ, rc(R_TAC+5'd2), rc(R_TAC+5'd2));
      6'd36: return mk(OP_MUL, R_TL, rc(R_TAB),      rc(R_TAB));
      6'd37: return mk(OP_MLA, R_TL, rc(R_TAB+5'd1), rc(R_TAB+5'd1));
      6'd38: return mk(OP_MLA, R_TL, rc(R_TAB+5'd2), rc(R_TAB+5'd2));
      // Gram determinants
      6'd39: return mk(OP_MUL, R_D,  rc(R_Q),  rc(R_L));
      6'd40: return mk(OP_MLS, R_D,  rc(R_S),  rc(R_S));
      6'd41: return mk(OP_MUL, R_DT, rc(R_TQ), rc(R_TL));
      6'd42: return mk(OP_MLS, R_DT, rc(R_TS), rc(R_TS));
      6'd43: return mk(OP_CHK, R_X,  rc(R_D),  rc(R_DT));
      // numerators
      6'd44: return mk(OP_MUL, R_N1, rc(R_U), rc(R_L));
      6'd45: return mk(OP_MLS, R_N1, rc(R_S), rc(R_W));
      6'd46: return mk(OP_MUL, R_N2, rc(R_Q), rc(R_W));
      6'd47: return mk(OP_MLS, R_N2, rc(R_S), rc(R_U));
      // per axis: X = TA*D + N1*TAC + N2*TAB, then X / D
      6'd48: return mk(OP_MUL, R_X,  rc(R_D),  V_TA);
      6'd49: return mk(OP_MLA, R_X,  rc(R_N1), rc(R_TAC));
      6'd50: return mk(OP_MLA, R_X,  rc(R_N2), rc(R_TAB));
      6'd51: return mk(OP_DIV, 5'd0, rc(R_X),  rc(R_D));
      6'd52: return mk(OP_MUL, R_X,  rc(R_D),  V_TA+6'd1);
      6'd53: return mk(OP_MLA, R_X,  rc(R_N1), rc(R_TAC+5'd1));
      6'd54: return mk(OP_MLA, R_X,  rc(R_N2), rc(R_TAB+5'd1));
      6'd55: return mk(OP_DIV, 5'd1, rc(R_X),  rc(R_D));
      6'd56: return mk(OP_MUL, R_X,  rc(R_D),  V_TA+6'd2);
      6'd57: return mk(OP_MLA, R_X,  rc(R_N1), rc(R_TAC+5'd2));
      6'd58: return mk(OP_MLA, R_X,  rc(R_N2), rc(R_TAB+5'd2));
      6'd59: return mk(OP_DIV, 5'd2, rc(R_X),  rc(R_D));
      default: return mk(OP_END, 5'd0, 6'd0, 6'd0);
    endcase
  endfunction

endpackage
`default_nettype wire

// ===== rtl/tpma_round.sv =====
// ----------------------------------------------------------------------------
// tpma_round
// Rounds a quotient half away from zero, applies sign, saturates to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none
module tpma_round import tpma_pkg::*; (
  input  logic [WIDE-1:0]      quo,
  input  logic [WIDE-1:0]      rem,
  input  logic [WIDE-1:0]      div,
  input  logic                 neg,
  output logic signed [CW-1:0] value
);

  localparam logic [WIDE-1:0] POS_MAX = {{(WIDE-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic [WIDE-1:0] NEG_MAX = {{(WIDE-CW){1'b0}}, 1'b1, {(CW-1){1'b0}}};

  logic            rnd;
  logic [WIDE-1:0] q;
  logic [WIDE-1:0] m;
  logic [WIDE-1:0] negm;

  // round up when twice the remainder reaches the divisor
  always_comb begin
    rnd  = ({rem, 1'b0} >= {1'b0, div});
    q    = quo + WIDE'(rnd);
    m    = (q > NEG_MAX) ? NEG_MAX : q;
    negm = '0 - m;
    if (!neg) begin
      value = (q > POS_MAX) ? POS_MAX[CW-1:0] : q[CW-1:0];
    end else begin
      value = negm[CW-1:0];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/triangle_point_map_affine_top.sv =====
// ----------------------------------------------------------------------------
// triangle_point_map_affine_top
// Maps a point of a source triangle onto a target triangle, exact integer math.
// ----------------------------------------------------------------------------
//  channel | signals                                       | handshake
//  in      | cmd, vertex_slot, coord_x, coord_y, coord_z   | in_valid / in_stall
//  out     | mapped_x, mapped_y, mapped_z, degenerate      | out_valid / out_stall
//
//  A map runs a 60-step micro-op program on a shared wide datapath:
//  multiplies go one multiplier bit a cycle, each of the three divides
//  takes 176 steps plus fetch and rounding, and a degenerate map ends after
//  the determinant check. in_stall is high while it runs. Synchronous reset
//  clears the vertices and control. A result waits in the output register
//  while new loads are taken.
`default_nettype none
`include "assert_macros.svh"
module triangle_point_map_affine_top import tpma_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           cmd,
  input  logic [1:0]           vertex_slot,
  input  logic signed [CW-1:0] coord_x,
  input  logic signed [CW-1:0] coord_y,
  input  logic signed [CW-1:0] coord_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [CW-1:0] mapped_x,
  output logic signed [CW-1:0] mapped_y,
  output logic signed [CW-1:0] mapped_z,
  output logic                 degenerate
);

  state_t          state, state_next;
  logic [5:0]      pc;
  uop_t            uop;
  logic [CW-1:0]   verts [0:17];
  logic [CW-1:0]   pt    [0:2];
  logic [WIDE-1:0] rf    [0:31];
  logic [WIDE-1:0] opa, opb, acc, ma, mb, prod, rem;
  logic            neg, deg;
  logic [7:0]      cnt;
  logic [CW-1:0]   res   [0:2];
  logic [5:0]      rd_code;
  logic [5:0]      pt_code;
  logic [WIDE-1:0] rdv;
  logic            in_fire, chk_zero, out_free;
  logic [4:0]      vbase;
  logic [WIDE-1:0] term, base, mres;
  logic [WIDE:0]   rem_sh;
  logic            ge;
  logic signed [CW-1:0] rnd_val;

  assign uop      = prog(pc);
  assign in_fire  = in_valid && !in_stall;
  assign chk_zero = (opa == '0) || (opb == '0);
  assign out_free = !out_valid || !out_stall;
  assign vbase    = ((cmd == CMD_TGT) ? 5'd9 : 5'd0) + {2'b0, vertex_slot, 1'b0}
                    + {3'b0, vertex_slot};

  // operand read port
  always_comb begin
    rd_code = (state == ST_FETCH_A) ? uop.sa : uop.sb;
    pt_code = rd_code - V_P;
    if (rd_code[5]) begin
      rdv = rf[rd_code[4:0]];
    end else if (rd_code < NUM_VERT) begin
      rdv = {{(WIDE-CW){verts[rd_code[4:0]][CW-1]}}, verts[rd_code[4:0]]};
    end else begin
      rdv = {{(WIDE-CW){pt[pt_code[1:0]][CW-1]}}, pt[pt_code[1:0]]};
    end
  end

  // multiply finish and divide step
  always_comb begin
    term   = neg ? ('0 - prod) : prod;
    base   = (uop.op == OP_MUL) ? '0 : acc;
    mres   = (uop.op == OP_MLS) ? (base - term) : (base + term);
    rem_sh = {rem, ma[WIDE-1]};
    ge     = (rem_sh >= {1'b0, mb});
  end

  tpma_round u_round (
    .quo   (prod),
    .rem   (rem),
    .div   (mb),
    .neg   (neg),
    .value (rnd_val)
  );

  // sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    in_stall   = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (in_valid && cmd == CMD_MAP) state_next = ST_FETCH_A;
      end
      ST_FETCH_A: begin
        state_next = (uop.op == OP_END) ? ST_EMIT : ST_FETCH_B;
      end
      ST_FETCH_B: state_next = ST_EXEC;
      ST_EXEC: begin
        case (uop.op)
          OP_SUB: state_next = ST_FETCH_A;
          OP_CHK: state_next = chk_zero ? ST_EMIT : ST_FETCH_A;
          OP_DIV: if (cnt == 8'd0) state_next = ST_ROUND;
          OP_MUL, OP_MLA, OP_MLS: if (mb == '0) state_next = ST_FETCH_A;
          default: state_next = ST_EMIT;
        endcase
      end
      ST_ROUND: state_next = ST_FETCH_A;
      ST_EMIT: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // vertex store, cleared by reset
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 18; i++) verts[i] <= '0;
    end else if (in_fire && (cmd == CMD_SRC || cmd == CMD_TGT)
                 && vertex_slot != SLOT_NONE) begin
      verts[vbase]      <= coord_x;
      verts[vbase+5'd1] <= coord_y;
      verts[vbase+5'd2] <= coord_z;
    end
  end

  // shared datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_fire && cmd == CMD_MAP) begin
          pt[0] <= coord_x;
          pt[1] <= coord_y;
          pt[2] <= coord_z;
          pc    <= '0;
          deg   <= 1'b0;
        end
      end
      ST_FETCH_A: opa <= rdv;
      ST_FETCH_B: begin
        opb  <= rdv;
        ma   <= opa[WIDE-1] ? ('0 - opa) : opa;
        mb   <= rdv[WIDE-1] ? ('0 - rdv) : rdv;
        neg  <= opa[WIDE-1] ^ rdv[WIDE-1];
        prod <= '0;
        rem  <= '0;
        cnt  <= 8'(WIDE - 1);
      end
      ST_EXEC: begin
        case (uop.op)
          OP_SUB: begin
            rf[uop.dst] <= opa - opb;
            pc          <= pc + 6'd1;
          end
          OP_CHK: begin
            deg <= chk_zero;
            pc  <= pc + 6'd1;
          end
          OP_DIV: begin
            rem  <= ge ? WIDE'(rem_sh - {1'b0, mb}) : rem_sh[WIDE-1:0];
            prod <= {prod[WIDE-2:0], ge};
            ma   <= {ma[WIDE-2:0], 1'b0};
            cnt  <= cnt - 8'd1;
          end
          OP_MUL, OP_MLA, OP_MLS: begin
            if (mb == '0) begin
              acc         <= mres;
              rf[uop.dst] <= mres;
              pc          <= pc + 6'd1;
            end else begin
              if (mb[0]) prod <= prod + ma;
              ma <= {ma[WIDE-2:0], 1'b0};
              mb <= {1'b0, mb[WIDE-1:1]};
            end
          end
          default: ;
        endcase
      end
      ST_ROUND: begin
        res[uop.dst[1:0]] <= rnd_val;
        pc                <= pc + 6'd1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_free) begin
      mapped_x   <= deg ? '0 : res[0];
      mapped_y   <= deg ? '0 : res[1];
      mapped_z   <= deg ? '0 : res[2];
      degenerate <= deg;
    end
  end

  // checks
  `AST_NEXT(a_map_busy, in_fire && cmd == CMD_MAP, in_stall)
  `AST_SAME(a_deg_zero, out_valid && degenerate, mapped_x == '0 && mapped_y == '0 && mapped_z == '0)
  `AST_SAME(a_emit_from_run, $rose(out_valid), $past(in_stall))

endmodule
`default_nettype wire
